[rtl/trimmed_mean_steering_select_assert.svh]
// Assertion macros used by the checker file of the trimmed mean steering selector.
`ifndef TRIMMED_MEAN_STEERING_SELECT_ASSERT_SVH
`define TRIMMED_MEAN_STEERING_SELECT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TMSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmss: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TMSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmss: next-cycle check failed");

`endif

[rtl/tmss_pkg.sv]
// Types, constants and register map of the trimmed mean steering selector.
package tmss_pkg;

	localparam int unsigned NCH      = 4;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned DUTY_W   = 8;
	localparam int unsigned WINDOW   = 10;

	// Window counter and accumulator widths follow the window length
	localparam int unsigned CNT_W = $clog2(WINDOW);
	localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);

	// Divide by WINDOW-2 as a multiply by a rounded-up reciprocal, exact for SUM_W-bit sums
	localparam int unsigned TRIM_DIV   = WINDOW - 2;
	localparam int unsigned TRIM_L     = $clog2(TRIM_DIV);
	localparam int unsigned RECIP_SH   = SUM_W + TRIM_L;
	localparam int unsigned RECIP_W    = SUM_W + 1;
	localparam int unsigned PROD_W     = SUM_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	// Configuration port
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [2:0] {
		REG_CH4_THR       = 3'd0,
		REG_CH3_RIGHT_THR = 3'd1,
		REG_CH3_MID_THR   = 3'd2,
		REG_CH3_HARD_THR  = 3'd3,
		REG_DUTY_MILD     = 3'd4,
		REG_DUTY_MIDDLE   = 3'd5,
		REG_DUTY_HARD     = 3'd6
	} reg_idx_t;

	localparam logic [SAMPLE_W-1:0] CH4_THR_RST       = 16'd1;
	localparam logic [SAMPLE_W-1:0] CH3_RIGHT_THR_RST = 16'd4;
	localparam logic [SAMPLE_W-1:0] CH3_MID_THR_RST   = 16'd5;
	localparam logic [SAMPLE_W-1:0] CH3_HARD_THR_RST  = 16'd1;
	localparam logic [DUTY_W-1:0]   DUTY_MILD_RST     = 8'd30;
	localparam logic [DUTY_W-1:0]   DUTY_MIDDLE_RST   = 8'd36;
	localparam logic [DUTY_W-1:0]   DUTY_HARD_RST     = 8'd42;

	typedef struct packed {
		logic [SAMPLE_W-1:0] ch4_threshold;
		logic [SAMPLE_W-1:0] ch3_right_threshold;
		logic [SAMPLE_W-1:0] ch3_mid_threshold;
		logic [SAMPLE_W-1:0] ch3_hard_threshold;
		logic [DUTY_W-1:0]   duty_mild;
		logic [DUTY_W-1:0]   duty_middle;
		logic [DUTY_W-1:0]   duty_hard;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] ch1_sample;
		logic [SAMPLE_W-1:0] ch2_sample;
		logic [SAMPLE_W-1:0] ch3_sample;
		logic [SAMPLE_W-1:0] ch4_sample;
	} sample_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] ch1_mean;
		logic [SAMPLE_W-1:0] ch2_mean;
		logic [SAMPLE_W-1:0] ch3_mean;
		logic [SAMPLE_W-1:0] ch4_mean;
		logic [DUTY_W-1:0]   steer_duty;
		logic                steer_changed;
	} result_t;

endpackage

[rtl/trimmed_mean_steering_select.sv]
// Trimmed mean over a window of sample sets with threshold-based steering duty selection.
//
//   channel   handshake               payload         request
//   sample    sample_valid/ready      sample_t        one set of four samples
//   result    result_valid/ready      result_t        means and duty, one per window
//   config    psel/penable/pwrite     paddr, pwdata   register write or read
//
// One sample set is taken every cycle while sample_ready is high. Taking the last set of a window
// loads the window totals register; the result register is then loaded from it through trim,
// reciprocal divide and the rules, once the result register has room.
// Reset clears the window count, stage valids, the held duty and restores register defaults.
// While a result waits and the window totals register is full, sample_ready drops.
module trimmed_mean_steering_select (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  tmss_pkg::sample_t                  sample_data,
	output logic                               result_valid,
	input  logic                               result_ready,
	output tmss_pkg::result_t                  result_data,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tmss_pkg::ADDR_W-1:0]        paddr,
	input  logic [tmss_pkg::DATA_W-1:0]        pwdata,
	output logic [tmss_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import tmss_pkg::*;

	cfg_t                 cfg_q;
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     sum_q [NCH];
	logic [SAMPLE_W-1:0]  min_q [NCH];
	logic [SAMPLE_W-1:0]  max_q [NCH];

	logic [SAMPLE_W-1:0]  smp [NCH];
	logic [SUM_W-1:0]     sum_nxt [NCH];
	logic [SAMPLE_W-1:0]  min_nxt [NCH];
	logic [SAMPLE_W-1:0]  max_nxt [NCH];

	logic                 v_s1;
	logic [SUM_W-1:0]     sum_s1 [NCH];
	logic [SAMPLE_W-1:0]  min_s1 [NCH];
	logic [SAMPLE_W-1:0]  max_s1 [NCH];
	logic [SUM_W-1:0]     trim [NCH];
	logic [PROD_W-1:0]    prod [NCH];
	logic [SAMPLE_W-1:0]  mean [NCH];

	logic                 accept, last_set;
	logic                 out_free, s1_free;

	logic                 result_valid_q;
	result_t              result_q;
	logic [DUTY_W-1:0]    held_duty_q;
	logic [DUTY_W-1:0]    duty_nxt;
	logic                 fired;

	// Configuration port: always ready, write on the access cycle
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ch4_threshold       <= CH4_THR_RST;
			cfg_q.ch3_right_threshold <= CH3_RIGHT_THR_RST;
			cfg_q.ch3_mid_threshold   <= CH3_MID_THR_RST;
			cfg_q.ch3_hard_threshold  <= CH3_HARD_THR_RST;
			cfg_q.duty_mild           <= DUTY_MILD_RST;
			cfg_q.duty_middle         <= DUTY_MIDDLE_RST;
			cfg_q.duty_hard           <= DUTY_HARD_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_CH4_THR:       cfg_q.ch4_threshold       <= pwdata[SAMPLE_W-1:0];
				REG_CH3_RIGHT_THR: cfg_q.ch3_right_threshold <= pwdata[SAMPLE_W-1:0];
				REG_CH3_MID_THR:   cfg_q.ch3_mid_threshold   <= pwdata[SAMPLE_W-1:0];
				REG_CH3_HARD_THR:  cfg_q.ch3_hard_threshold  <= pwdata[SAMPLE_W-1:0];
				REG_DUTY_MILD:     cfg_q.duty_mild           <= pwdata[DUTY_W-1:0];
				REG_DUTY_MIDDLE:   cfg_q.duty_middle         <= pwdata[DUTY_W-1:0];
				REG_DUTY_HARD:     cfg_q.duty_hard           <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero beyond the map
	always_comb begin
		case (reg_idx)
			REG_CH4_THR:       prdata = DATA_W'(cfg_q.ch4_threshold);
			REG_CH3_RIGHT_THR: prdata = DATA_W'(cfg_q.ch3_right_threshold);
			REG_CH3_MID_THR:   prdata = DATA_W'(cfg_q.ch3_mid_threshold);
			REG_CH3_HARD_THR:  prdata = DATA_W'(cfg_q.ch3_hard_threshold);
			REG_DUTY_MILD:     prdata = DATA_W'(cfg_q.duty_mild);
			REG_DUTY_MIDDLE:   prdata = DATA_W'(cfg_q.duty_middle);
			REG_DUTY_HARD:     prdata = DATA_W'(cfg_q.duty_hard);
			default:           prdata = '0;
		endcase
	end

	// Stage flow: the totals register moves when the result register has room
	assign out_free     = !result_valid_q || result_ready;
	assign s1_free      = !v_s1 || out_free;
	assign sample_ready = s1_free;
	assign accept       = sample_valid && sample_ready;
	assign last_set     = (cnt_q == CNT_W'(WINDOW - 1));

	assign smp[0] = sample_data.ch1_sample;
	assign smp[1] = sample_data.ch2_sample;
	assign smp[2] = sample_data.ch3_sample;
	assign smp[3] = sample_data.ch4_sample;

	// Accumulate; the first set of a window restarts sum, minimum and maximum
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			if (cnt_q == '0) begin
				sum_nxt[c] = SUM_W'(smp[c]);
				min_nxt[c] = smp[c];
				max_nxt[c] = smp[c];
			end else begin
				sum_nxt[c] = sum_q[c] + SUM_W'(smp[c]);
				min_nxt[c] = (smp[c] < min_q[c]) ? smp[c] : min_q[c];
				max_nxt[c] = (smp[c] > max_q[c]) ? smp[c] : max_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= last_set ? '0 : cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= sum_nxt[c];
				min_q[c] <= min_nxt[c];
				max_q[c] <= max_nxt[c];
			end
		end
	end

	// Capture the window totals on its last set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= accept && last_set;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_set) begin
			for (int c = 0; c < NCH; c++) begin
				sum_s1[c] <= sum_nxt[c];
				min_s1[c] <= min_nxt[c];
				max_s1[c] <= max_nxt[c];
			end
		end
	end

	// Drop the largest and smallest sample, then divide through the reciprocal
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			trim[c] = sum_s1[c] - SUM_W'(max_s1[c]) - SUM_W'(min_s1[c]);
			prod[c] = PROD_W'(trim[c]) * PROD_W'(RECIP);
			mean[c] = prod[c][RECIP_SH +: SAMPLE_W];
		end
	end

	// Apply the rules in order; a later rule overrides an earlier one
	always_comb begin
		duty_nxt = held_duty_q;
		fired    = 1'b0;
		if (mean[3] > cfg_q.ch4_threshold && mean[2] > cfg_q.ch3_right_threshold) begin
			duty_nxt = cfg_q.duty_mild;
			fired    = 1'b1;
		end
		if (mean[3] <= cfg_q.ch4_threshold && mean[2] <= cfg_q.ch3_mid_threshold) begin
			duty_nxt = cfg_q.duty_middle;
			fired    = 1'b1;
		end
		if (mean[3] <= cfg_q.ch4_threshold && mean[2] <= cfg_q.ch3_hard_threshold) begin
			duty_nxt = cfg_q.duty_hard;
			fired    = 1'b1;
		end
	end

	// Load the result register and hold the duty for the next window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			held_duty_q    <= '0;
		end else if (out_free) begin
			result_valid_q <= v_s1;
			if (v_s1) begin
				held_duty_q <= duty_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			result_q.ch1_mean      <= mean[0];
			result_q.ch2_mean      <= mean[1];
			result_q.ch3_mean      <= mean[2];
			result_q.ch4_mean      <= mean[3];
			result_q.steer_duty    <= duty_nxt;
			result_q.steer_changed <= fired;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

[rtl/tmss_checker.sv]
// Port-level checker of the trimmed mean steering selector and its bind.
`include "trimmed_mean_steering_select_assert.svh"

module tmss_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_ready,
	input  logic              result_valid,
	input  logic              result_ready,
	input  tmss_pkg::result_t result_data
);
	import tmss_pkg::*;

	logic [DUTY_W-1:0] last_duty_q;
	logic              res_take;

	assign res_take = result_valid && result_ready;

	// Track the duty of the last delivered result; it starts at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_duty_q <= '0;
		end else if (res_take) begin
			last_duty_q <= result_data.steer_duty;
		end
	end

	// A stalled result holds
	`TMSS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data))
	// Input stalls only behind a waiting result
	`TMSS_ASSERT_NOW(a_stall_cause, !sample_ready, result_valid)
	// No rule fired: the duty stays what it was
	`TMSS_ASSERT_NOW(a_duty_kept, res_take && !result_data.steer_changed, result_data.steer_duty == last_duty_q)
	// A pending sample request that is taken leaves ready intact unless a result waits
	`TMSS_ASSERT_NEXT(a_ready_after_take, sample_valid && sample_ready && !result_valid, sample_ready || result_valid)

endmodule

bind trimmed_mean_steering_select tmss_checker u_tmss_checker (.*);

[tb/tb_trimmed_mean_steering_select.sv]
// Self-checking testbench of the trimmed mean steering selector: window means and steering duty.
module tb_trimmed_mean_steering_select;
	import tmss_pkg::*;

	localparam logic [2:0] UNMAPPED_IDX = 3'd7;
	localparam int         SETTLE_CYCLES = 12;

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_ready;
	sample_t           sample_data;
	logic              result_valid;
	logic              result_ready;
	result_t           result_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	trimmed_mean_steering_select DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Pending sample sets and expected window results
	sample_t sample_q[$];
	result_t means_q[$];
	int      offered_cnt = 0;
	int      taken_cnt   = 0;
	int      err_count   = 0;

	// Idling controls
	int      send_gap_pct   = 0;
	int      take_stall_pct = 0;
	logic    hold_results   = 1'b0;

	// Predictor state and register shadow
	cfg_t            cfg_shadow;
	int              win_count;
	logic [21:0]     win_sum [NCH];
	logic [15:0]     win_min [NCH];
	logic [15:0]     win_max [NCH];
	logic [7:0]      held_duty;

	// Stimulus shaping state
	int              gen_count = 0;
	logic [15:0]     lvl [NCH];
	int              spread;
	logic            noisy;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// Fold one sample set into the window; on the last set, queue the expected result
	task automatic fold_sample_set(input sample_t s);
		logic [15:0] v [NCH];
		logic [15:0] m [NCH];
		logic [21:0] trimmed;
		logic        fired;
		result_t     r;
		v[0] = s.ch1_sample;
		v[1] = s.ch2_sample;
		v[2] = s.ch3_sample;
		v[3] = s.ch4_sample;
		for (int c = 0; c < NCH; c++) begin
			if (win_count == 0) begin
				win_sum[c] = 22'(v[c]);
				win_min[c] = v[c];
				win_max[c] = v[c];
			end else begin
				win_sum[c] = win_sum[c] + 22'(v[c]);
				if (v[c] < win_min[c]) win_min[c] = v[c];
				if (v[c] > win_max[c]) win_max[c] = v[c];
			end
		end
		if (win_count + 1 < WINDOW) begin
			win_count++;
			return;
		end
		win_count = 0;
		for (int c = 0; c < NCH; c++) begin
			trimmed = win_sum[c] - 22'(win_max[c]) - 22'(win_min[c]);
			m[c] = 16'(trimmed / (WINDOW - 2));
		end
		// Later rules override earlier ones
		fired = 1'b0;
		if (m[3] > cfg_shadow.ch4_threshold && m[2] > cfg_shadow.ch3_right_threshold) begin
			held_duty = cfg_shadow.duty_mild;
			fired = 1'b1;
		end
		if (m[3] <= cfg_shadow.ch4_threshold && m[2] <= cfg_shadow.ch3_mid_threshold) begin
			held_duty = cfg_shadow.duty_middle;
			fired = 1'b1;
		end
		if (m[3] <= cfg_shadow.ch4_threshold && m[2] <= cfg_shadow.ch3_hard_threshold) begin
			held_duty = cfg_shadow.duty_hard;
			fired = 1'b1;
		end
		r.ch1_mean      = m[0];
		r.ch2_mean      = m[1];
		r.ch3_mean      = m[2];
		r.ch4_mean      = m[3];
		r.steer_duty    = held_duty;
		r.steer_changed = fired;
		means_q.push_back(r);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (means_q.size() == 0) begin
			flag_mismatch("unexpected result", 32'(got.ch1_mean), 32'd0);
			return;
		end
		want = means_q.pop_front();
		if (got.ch1_mean !== want.ch1_mean)
			flag_mismatch("ch1_mean", 32'(got.ch1_mean), 32'(want.ch1_mean));
		if (got.ch2_mean !== want.ch2_mean)
			flag_mismatch("ch2_mean", 32'(got.ch2_mean), 32'(want.ch2_mean));
		if (got.ch3_mean !== want.ch3_mean)
			flag_mismatch("ch3_mean", 32'(got.ch3_mean), 32'(want.ch3_mean));
		if (got.ch4_mean !== want.ch4_mean)
			flag_mismatch("ch4_mean", 32'(got.ch4_mean), 32'(want.ch4_mean));
		if (got.steer_duty !== want.steer_duty)
			flag_mismatch("steer_duty", 32'(got.steer_duty), 32'(want.steer_duty));
		if (got.steer_changed !== want.steer_changed)
			flag_mismatch("steer_changed", 32'(got.steer_changed), 32'(want.steer_changed));
	endtask

	// Monitor: check results and predict accepted requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) check_result(result_data);
			if (sample_valid && sample_ready) begin
				fold_sample_set(sample_data);
				taken_cnt++;
			end
		end
	end

	// Driver: present the next request once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (taken_cnt == offered_cnt) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				sample_data  <= sample_q.pop_front();
				sample_valid <= 1'b1;
				offered_cnt++;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random, or hold off entirely
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= !hold_results && ($urandom_range(99) >= take_stall_pct);
		end
	end

	task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] shadow_value(input reg_idx_t idx);
		case (idx)
			REG_CH4_THR:       return DATA_W'(cfg_shadow.ch4_threshold);
			REG_CH3_RIGHT_THR: return DATA_W'(cfg_shadow.ch3_right_threshold);
			REG_CH3_MID_THR:   return DATA_W'(cfg_shadow.ch3_mid_threshold);
			REG_CH3_HARD_THR:  return DATA_W'(cfg_shadow.ch3_hard_threshold);
			REG_DUTY_MILD:     return DATA_W'(cfg_shadow.duty_mild);
			REG_DUTY_MIDDLE:   return DATA_W'(cfg_shadow.duty_middle);
			default:           return DATA_W'(cfg_shadow.duty_hard);
		endcase
	endfunction

	// Write a register; only the low bits of the register's width are kept
	task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] rd;
		apb_xfer(1'b1, {idx, 2'b00}, v, rd);
		case (idx)
			REG_CH4_THR:       cfg_shadow.ch4_threshold       = v[15:0];
			REG_CH3_RIGHT_THR: cfg_shadow.ch3_right_threshold = v[15:0];
			REG_CH3_MID_THR:   cfg_shadow.ch3_mid_threshold   = v[15:0];
			REG_CH3_HARD_THR:  cfg_shadow.ch3_hard_threshold  = v[15:0];
			REG_DUTY_MILD:     cfg_shadow.duty_mild           = v[7:0];
			REG_DUTY_MIDDLE:   cfg_shadow.duty_middle         = v[7:0];
			REG_DUTY_HARD:     cfg_shadow.duty_hard           = v[7:0];
			default:           ;
		endcase
	endtask

	// Read back every register against the shadow
	task automatic check_regs();
		logic [DATA_W-1:0] rd;
		reg_idx_t          idx;
		idx = idx.first();
		do begin
			apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
			if (rd !== shadow_value(idx))
				flag_mismatch(idx.name(), rd, shadow_value(idx));
			idx = idx.next();
		end while (idx != idx.first());
	endtask

	// Program all registers: 0 random, 1 all low, 2 all high, 3 small thresholds
	task automatic program_regs(input int style);
		reg_idx_t idx;
		idx = idx.first();
		do begin
			case (style)
				0:       set_reg(idx, $urandom());
				1:       set_reg(idx, 32'hFFFF_0000 | ((idx >= REG_DUTY_MILD) ? 32'h0000_FF00 : 32'h0));
				2:       set_reg(idx, 32'hFFFF_FFFF);
				default: set_reg(idx, (idx >= REG_DUTY_MILD) ? $urandom() : $urandom_range(20));
			endcase
			idx = idx.next();
		end while (idx != idx.first());
		check_regs();
	endtask

	// Hold the sender until every request is taken and every result is back
	task automatic wait_idle();
		while (sample_q.size() != 0 || offered_cnt != taken_cnt || means_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] clamp16(input int v);
		if (v < 0) return 16'd0;
		if (v > 65535) return 16'hFFFF;
		return 16'(v);
	endfunction

	function automatic logic [15:0] pick_center(input logic [15:0] thr);
		case ($urandom_range(3))
			0:       return 16'($urandom_range(65535));
			1:       return clamp16(int'(thr) + int'($urandom_range(4)) - 2);
			2:       return 16'($urandom_range(6));
			default: return 16'(65535 - $urandom_range(6));
		endcase
	endfunction

	task automatic push_set(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d);
		sample_t s;
		s.ch1_sample = a;
		s.ch2_sample = b;
		s.ch3_sample = c;
		s.ch4_sample = d;
		sample_q.push_back(s);
		gen_count++;
	endtask

	// Queue sample sets, choosing a fresh level per channel at each window start
	task automatic queue_sets(input int n);
		logic [15:0] v [NCH];
		logic [15:0] ch3_thr;
		for (int i = 0; i < n; i++) begin
			if (gen_count % WINDOW == 0) begin
				case ($urandom_range(2))
					0:       ch3_thr = cfg_shadow.ch3_right_threshold;
					1:       ch3_thr = cfg_shadow.ch3_mid_threshold;
					default: ch3_thr = cfg_shadow.ch3_hard_threshold;
				endcase
				noisy  = ($urandom_range(7) == 0);
				spread = ($urandom_range(3) == 0) ? $urandom_range(2000) : $urandom_range(2);
				lvl[0] = pick_center(16'($urandom()));
				lvl[1] = pick_center(16'($urandom()));
				lvl[2] = pick_center(ch3_thr);
				lvl[3] = pick_center(cfg_shadow.ch4_threshold);
			end
			for (int c = 0; c < NCH; c++) begin
				if (noisy || $urandom_range(11) == 0)
					v[c] = 16'($urandom_range(65535));
				else
					v[c] = clamp16(int'(lvl[c]) + int'($urandom_range(2 * spread)) - spread);
			end
			push_set(v[0], v[1], v[2], v[3]);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_data  = '0;
		result_ready = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		cfg_shadow = '{CH4_THR_RST, CH3_RIGHT_THR_RST, CH3_MID_THR_RST, CH3_HARD_THR_RST,
			DUTY_MILD_RST, DUTY_MIDDLE_RST, DUTY_HARD_RST};
		win_count = 0;
		held_duty = '0;
		for (int c = 0; c < NCH; c++) begin
			win_sum[c] = '0;
			win_min[c] = '0;
			win_max[c] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Reset defaults, then directed windows
		check_regs();
		// No rule fires: duty stays at its reset value; extremes trimmed away
		for (int i = 0; i < WINDOW; i++)
			push_set(i[0] ? 16'hFFFF : 16'h0000, 16'hFFFF,
				(i == 3) ? 16'hFFFF : ((i == 6) ? 16'h0000 : 16'd3),
				(i == 2) ? 16'h0000 : ((i == 8) ? 16'hFFFF : 16'd2));
		// Both channels very low: hard duty overrides middle
		for (int i = 0; i < WINDOW; i++)
			push_set(i[0] ? 16'h5555 : 16'hAAAA, 16'h0000, 16'h0000, 16'h0000);
		queue_sets(100);
		wait_idle();

		// Random settings, no idling; out-of-map write must be ignored
		program_regs(0);
		begin
			logic [DATA_W-1:0] rd;
			apb_xfer(1'b1, {UNMAPPED_IDX, 2'b00}, $urandom(), rd);
		end
		check_regs();
		queue_sets(225);
		wait_idle();

		// All registers at their low extreme, sender idle half the time
		program_regs(1);
		send_gap_pct = 50;
		queue_sets(215);
		wait_idle();

		// All registers at their high extreme, receiver stalling half the time
		program_regs(2);
		send_gap_pct   = 0;
		take_stall_pct = 50;
		queue_sets(220);
		wait_idle();

		// Small thresholds, both sides idling
		program_regs(3);
		send_gap_pct   = 38;
		take_stall_pct = 38;
		queue_sets(205);
		wait_idle();

		// Receiver holds off while the sender keeps offering until the input stalls
		program_regs(3);
		send_gap_pct   = 0;
		take_stall_pct = 0;
		fork
			begin
				hold_results = 1'b1;
				repeat (300) @(posedge clk);
				hold_results = 1'b0;
			end
		join_none
		queue_sets(150);
		wait_idle();

		if (err_count == 0 && means_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
